/* hdl/assert_macros.svh */
// Assertion macros used by the checker file sobol_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/sobol_pkg.sv */
// Types, constants and a helper function for the Sobol sequence generator.
// No dependencies.
package sobol_pkg;

  localparam int OUT_W     = 32;
  localparam int CFG_W     = 36;
  localparam int CNT_W     = 32;
  localparam int DEG_W     = 4;
  localparam int COEF_W    = 7;
  localparam int MPACK_W   = 36;
  localparam int MFIELD_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]   POINT_COUNT_RST = 32'd16;
  localparam logic [DEG_W-1:0]   POLY_DEGREE_RST = 4'd1;
  localparam logic [COEF_W-1:0]  POLY_COEFFS_RST = 7'd0;
  localparam logic [MPACK_W-1:0] INIT_M_RST      = 36'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_POLY_DEGREE = 2'd1,
    REG_POLY_COEFFS = 2'd2,
    REG_INIT_M      = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BUILD = 4'b0010,
    ST_READ  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  // m_i sits at bit offset i(i-1)/2 and is i bits wide
  function automatic logic [MFIELD_W-1:0] m_field(input logic [MPACK_W-1:0] pk,
                                                  input logic [DEG_W-1:0] i);
    logic [MFIELD_W-1:0] r;
    int off;
    r   = '0;
    off = 0;
    for (int k = 1; k <= MFIELD_W; k++) begin
      if (i == DEG_W'(k)) begin
        r = MFIELD_W'((pk >> off) & ((MPACK_W'(1) << k) - MPACK_W'(1)));
      end
      off = off + k;
    end
    return r;
  endfunction

endpackage

/* hdl/sobol_dir_unit.sv */
// Direction number builder and store for the second dimension.
// Runs the recurrence one entry per cycle into a small memory. Uses sobol_pkg.
module sobol_dir_unit #(
  parameter int FRACTION_BITS = 32,
  parameter int MAX_DEGREE    = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [sobol_pkg::DEG_W-1:0]         poly_degree,
  input  logic [sobol_pkg::COEF_W-1:0]        poly_coeffs,
  input  logic [sobol_pkg::MPACK_W-1:0]       init_m_packed,
  output logic                                busy,
  input  logic                                rd_en,
  input  logic [$clog2(FRACTION_BITS)-1:0]    rd_addr,
  output logic [FRACTION_BITS-1:0]            rd_data
);

  localparam int AW = $clog2(FRACTION_BITS);
  localparam int SW = $clog2(MAX_DEGREE + 1);

  logic [AW-1:0]                    j;
  logic [SW-1:0]                    s;
  logic [sobol_pkg::COEF_W-1:0]     coef;
  logic [sobol_pkg::MPACK_W-1:0]    m_pk;
  logic [FRACTION_BITS-1:0]         win [1:MAX_DEGREE];
  logic [FRACTION_BITS-1:0]         mem [FRACTION_BITS];

  logic [SW-1:0]                    s_next;
  logic [sobol_pkg::MFIELD_W-1:0]   m_val;
  logic [FRACTION_BITS-1:0]         v_seed;
  logic [FRACTION_BITS-1:0]         v_back;
  logic [FRACTION_BITS-1:0]         v_rec;
  logic [FRACTION_BITS-1:0]         v_new;

  always_comb begin
    if (poly_degree == '0) begin
      s_next = SW'(1);
    end else if (int'(poly_degree) > MAX_DEGREE) begin
      s_next = SW'(MAX_DEGREE);
    end else begin
      s_next = SW'(poly_degree);
    end
  end

  always_comb begin
    m_val  = sobol_pkg::m_field(m_pk, sobol_pkg::DEG_W'(int'(j) + 1));
    v_seed = FRACTION_BITS'(m_val) << (FRACTION_BITS - 1 - int'(j));
    v_back = '0;
    for (int k = 1; k <= MAX_DEGREE; k++) begin
      if (int'(s) == k) begin
        v_back = win[k];
      end
    end
    v_rec = v_back ^ (v_back >> s);
    for (int k = 1; k < MAX_DEGREE; k++) begin
      if ((k < int'(s)) && coef[3'(int'(s) - 1 - k)]) begin
        v_rec = v_rec ^ win[k];
      end
    end
    v_new = (int'(j) < int'(s)) ? v_seed : v_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      j    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      j    <= '0;
    end else if (busy) begin
      if (j == AW'(FRACTION_BITS - 1)) begin
        busy <= 1'b0;
      end else begin
        j <= j + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s    <= s_next;
      coef <= poly_coeffs;
      m_pk <= init_m_packed;
    end
    if (busy) begin
      win[1] <= v_new;
      for (int k = 2; k <= MAX_DEGREE; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[j] <= v_new;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/sobol_sequence_generator.sv */
// Two-dimensional Sobol point generator in Gray-code order, top level.
// Uses sobol_pkg and sobol_dir_unit.
//
// One transaction on the input gives one point on the output. A normal tick
// reads the direction number from the store at the accepting edge, applies
// the XOR update in ST_READ and then raises out_valid. A restart tick waits
// in ST_BUILD while the second-dimension direction numbers are rebuilt one
// per cycle through the recurrence unit, then raises out_valid. A tick at
// the saturated index goes straight to the output. The block takes a new
// input only after the previous point has been taken. Configuration
// registers apply to the second dimension at the next restart; a restart
// must come before the first point.
module sobol_sequence_generator #(
  parameter int FRACTION_BITS = 32,
  parameter int MAX_DEGREE    = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [sobol_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sobol_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sobol_pkg::OUT_W-1:0]         point_index,
  output logic [sobol_pkg::OUT_W-1:0]         coord_x,
  output logic [sobol_pkg::OUT_W-1:0]         coord_y,
  output logic                                last_point,
  output logic                                exhausted
);

  localparam int AW    = $clog2(FRACTION_BITS);
  localparam int OUT_W = sobol_pkg::OUT_W;

  sobol_pkg::state_t                   state;
  logic [sobol_pkg::CNT_W-1:0]         point_count;
  logic [sobol_pkg::DEG_W-1:0]         poly_degree;
  logic [sobol_pkg::COEF_W-1:0]        poly_coeffs;
  logic [sobol_pkg::MPACK_W-1:0]       init_m_packed;

  logic [FRACTION_BITS-1:0]            cur_index;
  logic [FRACTION_BITS-1:0]            cur_x;
  logic [FRACTION_BITS-1:0]            cur_y;
  logic                                exh;
  logic [AW-1:0]                       tpos;

  logic                                in_fire;
  logic                                dir_busy;
  logic                                rd_en;
  logic [FRACTION_BITS-1:0]            rd_data;
  logic [AW-1:0]                       ones_cnt;
  logic                                idx_full;

  assign in_ready  = (state == sobol_pkg::ST_IDLE);
  assign out_valid = (state == sobol_pkg::ST_OUT);
  assign in_fire   = in_valid && in_ready;
  assign rd_en     = in_fire && !restart && !idx_full;

  // position of the lowest zero bit of the index
  always_comb begin
    ones_cnt = '0;
    for (int b = FRACTION_BITS - 1; b >= 0; b--) begin
      if (!cur_index[b]) begin
        ones_cnt = AW'(b);
      end
    end
    idx_full = &cur_index;
  end

  sobol_dir_unit #(
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_DEGREE    (MAX_DEGREE)
  ) u_dir (
    .clk           (clk),
    .rst           (rst),
    .start         (in_fire && restart),
    .poly_degree   (poly_degree),
    .poly_coeffs   (poly_coeffs),
    .init_m_packed (init_m_packed),
    .busy          (dir_busy),
    .rd_en         (rd_en),
    .rd_addr       (ones_cnt),
    .rd_data       (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= sobol_pkg::POINT_COUNT_RST;
      poly_degree   <= sobol_pkg::POLY_DEGREE_RST;
      poly_coeffs   <= sobol_pkg::POLY_COEFFS_RST;
      init_m_packed <= sobol_pkg::INIT_M_RST;
    end else if (cfg_write_en) begin
      unique case (sobol_pkg::cfg_reg_t'(cfg_index))
        sobol_pkg::REG_POINT_COUNT: point_count   <= cfg_data[sobol_pkg::CNT_W-1:0];
        sobol_pkg::REG_POLY_DEGREE: poly_degree   <= cfg_data[sobol_pkg::DEG_W-1:0];
        sobol_pkg::REG_POLY_COEFFS: poly_coeffs   <= cfg_data[sobol_pkg::COEF_W-1:0];
        sobol_pkg::REG_INIT_M:      init_m_packed <= cfg_data[sobol_pkg::MPACK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sobol_pkg::ST_IDLE;
      cur_index <= '0;
      cur_x     <= '0;
      cur_y     <= '0;
      exh       <= 1'b0;
      tpos      <= '0;
    end else begin
      unique case (state)
        sobol_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (restart) begin
              cur_index <= '0;
              cur_x     <= '0;
              cur_y     <= '0;
              exh       <= 1'b0;
              state     <= sobol_pkg::ST_BUILD;
            end else if (idx_full) begin
              exh   <= 1'b1;
              state <= sobol_pkg::ST_OUT;
            end else begin
              tpos  <= ones_cnt;
              state <= sobol_pkg::ST_READ;
            end
          end
        end
        sobol_pkg::ST_BUILD: begin
          if (!dir_busy) begin
            state <= sobol_pkg::ST_OUT;
          end
        end
        sobol_pkg::ST_READ: begin
          cur_y     <= cur_y ^ rd_data;
          cur_x     <= cur_x ^ (FRACTION_BITS'(1) << (FRACTION_BITS - 1 - int'(tpos)));
          cur_index <= cur_index + FRACTION_BITS'(1);
          exh       <= 1'b0;
          state     <= sobol_pkg::ST_OUT;
        end
        sobol_pkg::ST_OUT: begin
          if (out_ready) begin
            state <= sobol_pkg::ST_IDLE;
          end
        end
        default: state <= sobol_pkg::ST_IDLE;
      endcase
    end
  end

  assign point_index = OUT_W'(cur_index);
  assign coord_x     = OUT_W'(cur_x) << (OUT_W - FRACTION_BITS);
  assign coord_y     = OUT_W'(cur_y) << (OUT_W - FRACTION_BITS);
  assign last_point  = (point_index == (point_count - sobol_pkg::CNT_W'(1)));
  assign exhausted   = exh;

endmodule

/* hdl/sobol_checker.sv */
// Port-level checks for the Sobol sequence generator, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module sobol_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] point_index,
  input logic [31:0] coord_x,
  input logic [31:0] coord_y
);

  // one transaction in flight at a time
  `ASSERT_ALWAYS(a_no_overlap, clk, rst, !(in_ready && out_valid))

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // point 0 is the origin
  `ASSERT_IMPLIES(a_point0_zero, clk, rst, out_valid && (point_index == 32'd0),
                  (coord_x == 32'd0) && (coord_y == 32'd0))

  // top bit of x is bit 0 of the Gray code of the index
  `ASSERT_IMPLIES(a_x_msb_gray, clk, rst, out_valid,
                  coord_x[31] == (point_index[0] ^ point_index[1]))

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
               out_valid && $stable(point_index) && $stable(coord_x) && $stable(coord_y))

endmodule

bind sobol_sequence_generator sobol_checker u_sobol_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .point_index (point_index),
  .coord_x     (coord_x),
  .coord_y     (coord_y)
);
